// ----- hw/rtl/rfr_pkg.sv -----
// Shared constants, types and the CRC-16/CCITT-FALSE byte update for the
// request frame receiver. No dependencies.
package rfr_pkg;

    // Field tags, which double as parser phase codes
    localparam logic [2:0] PH_TYPE    = 3'd0;
    localparam logic [2:0] PH_ID      = 3'd1;
    localparam logic [2:0] PH_KEY     = 3'd2;
    localparam logic [2:0] PH_IV      = 3'd3;
    localparam logic [2:0] PH_LEN     = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_CRC     = 3'd6;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CRC_BAD  = 2'd1;
    localparam logic [1:0] ST_TIMEOUT  = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    // Input kinds carried on tuser
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Configuration register indexes
    localparam logic CFG_IDLE_TIMEOUT = 1'b0;
    localparam logic CFG_MAX_PAYLOAD  = 1'b1;

    localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd10000;
    localparam logic [15:0] MAX_PAYLOAD_RST  = 16'd1024;
    localparam logic [15:0] CRC_INIT         = 16'hFFFF;
    localparam logic [15:0] CRC_POLY         = 16'h1021;

    localparam int ID_BYTES_DEF  = 16;
    localparam int KEY_BYTES_DEF = 32;
    localparam int IV_BYTES_DEF  = 16;

    localparam int TYPE_BYTES = 2;
    localparam int LEN_BYTES  = 4;

    localparam int TDATA_W = 48;

    typedef logic [15:0] word16_t;

    // One byte of CRC-16/CCITT-FALSE, MSB first
    function automatic word16_t crc16_byte(input word16_t crc_in, input logic [7:0] b);
        word16_t c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/request_frame_receiver_crc16_unit.sv -----
// Top level of the length-prefixed request frame receiver with CRC-16 check.
// Depends on rfr_pkg (phase codes, status codes, CRC byte update).
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+-------------------------------
//   s_axis   | in        | tvalid/tready          | tdata rx_byte, tuser cmd
//   m_axis   | out       | tvalid/tready, tlast   | tdata byte/offset/len/status,
//            |           |                        | tuser field_tag
//   cfg      | in        | cfg_we (always taken)  | cfg_addr, cfg_wdata
//
// One transaction per cycle sustained while m_axis does not stall: a transaction
// sits in the input register, is parsed and CRC-updated in a single combinational
// pass, and its result, if it has one, lands in the result register that drives
// m_axis_tvalid.
// aresetn is synchronous, active low; it restarts the parser at the type field
// and restores the register defaults (timeout 10000 ms, max payload 1024).
// A stalled m_axis holds the result register and, through it, the input
// register; s_axis_tready drops only when both are full.
module request_frame_receiver_crc16_unit #(
    parameter int ID_BYTES  = rfr_pkg::ID_BYTES_DEF,
    parameter int KEY_BYTES = rfr_pkg::KEY_BYTES_DEF,
    parameter int IV_BYTES  = rfr_pkg::IV_BYTES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,   // [7:0] rx_byte
    input  logic                       s_axis_tuser,   // [0] cmd

    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [7:0] out_byte, [23:8] field_offset, [39:24] payload_len,
    // [41:40] status, [47:42] zero
    output logic [rfr_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [2:0]                 m_axis_tuser,   // [2:0] field_tag
    output logic                       m_axis_tlast,   // frame_end

    input  logic                       cfg_we,
    input  logic                       cfg_addr,
    input  logic [15:0]                cfg_wdata
);
    import rfr_pkg::*;

    localparam logic [16:0] ID_SIZE   = 17'(ID_BYTES);
    localparam logic [16:0] KEY_SIZE  = 17'(KEY_BYTES);
    localparam logic [16:0] IV_SIZE   = 17'(IV_BYTES);
    localparam logic [16:0] TYPE_CNT  = 17'(TYPE_BYTES);
    localparam logic [16:0] LEN_SIZE  = 17'(LEN_BYTES);

    // Configuration registers
    logic [15:0] idle_timeout_reg;
    logic [15:0] max_payload_reg;

    // Input register
    logic        in_valid_reg;
    logic        in_cmd_reg;
    logic [7:0]  in_byte_reg;

    // Parser state
    logic [2:0]  phase_reg,        phase_next;
    logic [15:0] byte_offset_reg,  byte_offset_next;
    logic [31:0] length_reg,       length_next;
    logic [15:0] crc_reg,          crc_next;
    logic [7:0]  crc_high_reg,     crc_high_next;
    logic [15:0] idle_count_reg,   idle_count_next;
    logic        started_reg,      started_next;

    // Result register
    logic        m_valid_reg;
    logic [7:0]  r_byte_reg,       r_byte_next;
    logic [2:0]  r_tag_reg;
    logic [15:0] r_offset_reg;
    logic [15:0] r_len_reg,        r_len_next;
    logic        r_end_reg,        r_end_next;
    logic [1:0]  r_status_reg,     r_status_next;
    logic        r_has_next;

    logic        out_free;
    logic        proc_fire;
    logic [16:0] off_inc;
    logic [16:0] hdr_size;
    logic [15:0] crc_upd;
    logic        restart;

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign proc_fire     = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    assign off_inc = {1'b0, byte_offset_reg} + 17'd1;
    assign crc_upd = crc16_byte(crc_reg, in_byte_reg);

    always_comb begin
        unique case (phase_reg)
            PH_TYPE: hdr_size = TYPE_CNT;
            PH_ID:   hdr_size = ID_SIZE;
            PH_KEY:  hdr_size = KEY_SIZE;
            PH_IV:   hdr_size = IV_SIZE;
            default: hdr_size = LEN_SIZE;
        endcase
    end

    // Parse one transaction from the input register
    always_comb begin
        phase_next       = phase_reg;
        byte_offset_next = byte_offset_reg;
        length_next      = length_reg;
        crc_next         = crc_reg;
        crc_high_next    = crc_high_reg;
        idle_count_next  = idle_count_reg;
        started_next     = started_reg;
        r_byte_next      = in_byte_reg;
        r_end_next       = 1'b0;
        r_status_next    = ST_OK;
        r_has_next       = 1'b0;
        restart          = 1'b0;

        if (in_cmd_reg == CMD_TICK) begin
            r_byte_next = 8'd0;
            if (started_reg) begin
                if (idle_count_reg != 16'hFFFF) begin
                    idle_count_next = idle_count_reg + 16'd1;
                end
                if (idle_count_next >= idle_timeout_reg) begin
                    r_has_next    = 1'b1;
                    r_end_next    = 1'b1;
                    r_status_next = ST_TIMEOUT;
                    restart       = 1'b1;
                end
            end
        end else begin
            r_has_next      = 1'b1;
            idle_count_next = 16'd0;
            started_next    = 1'b1;
            if (phase_reg <= PH_LEN) begin
                crc_next = crc_upd;
                if (phase_reg == PH_LEN) begin
                    length_next = {length_reg[23:0], in_byte_reg};
                end
                if (off_inc >= hdr_size) begin
                    byte_offset_next = 16'd0;
                    if (phase_reg == PH_LEN) begin
                        if (length_next > {16'd0, max_payload_reg}) begin
                            r_end_next    = 1'b1;
                            r_status_next = ST_TOO_LONG;
                            restart       = 1'b1;
                        end else if (length_next == 32'd0) begin
                            phase_next = PH_CRC;
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end else begin
                        phase_next = phase_reg + 3'd1;
                    end
                end else begin
                    byte_offset_next = off_inc[15:0];
                end
            end else if (phase_reg == PH_PAYLOAD) begin
                crc_next = crc_upd;
                if ({15'd0, off_inc} >= length_reg) begin
                    byte_offset_next = 16'd0;
                    phase_next       = PH_CRC;
                end else begin
                    byte_offset_next = off_inc[15:0];
                end
            end else begin
                if (byte_offset_reg == 16'd0) begin
                    crc_high_next    = in_byte_reg;
                    byte_offset_next = 16'd1;
                end else begin
                    r_end_next    = 1'b1;
                    r_status_next = ({crc_high_reg, in_byte_reg} == crc_reg) ?
                                    ST_OK : ST_CRC_BAD;
                    restart       = 1'b1;
                end
            end
        end

        // Length as reported, saturated to 16 bits
        r_len_next = (length_next[31:16] != 16'd0) ? 16'hFFFF : length_next[15:0];

        if (restart) begin
            phase_next       = PH_TYPE;
            byte_offset_next = 16'd0;
            length_next      = 32'd0;
            crc_next         = CRC_INIT;
            crc_high_next    = 8'd0;
            idle_count_next  = 16'd0;
            started_next     = 1'b0;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_timeout_reg <= IDLE_TIMEOUT_RST;
            max_payload_reg  <= MAX_PAYLOAD_RST;
        end else if (cfg_we) begin
            if (cfg_addr == CFG_IDLE_TIMEOUT) begin
                idle_timeout_reg <= cfg_wdata;
            end else begin
                max_payload_reg <= cfg_wdata;
            end
        end
    end

    // Input register: load on every accepted transaction, hold while stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_cmd_reg  <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
    end

    // Parser state: advance once per processed transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_TYPE;
            byte_offset_reg <= 16'd0;
            length_reg      <= 32'd0;
            crc_reg         <= CRC_INIT;
            crc_high_reg    <= 8'd0;
            idle_count_reg  <= 16'd0;
            started_reg     <= 1'b0;
        end else if (proc_fire) begin
            phase_reg       <= phase_next;
            byte_offset_reg <= byte_offset_next;
            length_reg      <= length_next;
            crc_reg         <= crc_next;
            crc_high_reg    <= crc_high_next;
            idle_count_reg  <= idle_count_next;
            started_reg     <= started_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= proc_fire && r_has_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && r_has_next) begin
            r_byte_reg   <= r_byte_next;
            r_tag_reg    <= phase_reg;
            r_offset_reg <= byte_offset_reg;
            r_len_reg    <= r_len_next;
            r_end_reg    <= r_end_next;
            r_status_reg <= r_status_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'd0, r_status_reg, r_len_reg, r_offset_reg, r_byte_reg};
    assign m_axis_tuser  = r_tag_reg;
    assign m_axis_tlast  = r_end_reg;

`ifndef SYNTHESIS
    // With no frame under way the parser sits at the start of the type field
    a_idle_at_type: assert property (@(posedge aclk) disable iff (!aresetn)
        !started_reg |-> (phase_reg == PH_TYPE) && (byte_offset_reg == 16'd0))
        else $error("parser not at type field while no frame is in progress");

    // A frame end restores the CRC seed and the type phase
    a_end_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && r_has_next && r_end_next) |=>
            (phase_reg == PH_TYPE) && (crc_reg == CRC_INIT) && !started_reg)
        else $error("frame end did not restart the parser");

    // Payload phase only with a nonzero 16-bit length
    a_payload_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAYLOAD) |->
            (length_reg[31:16] == 16'd0) && (length_reg[15:0] != 16'd0))
        else $error("payload phase with an out-of-range length");

    // A timeout abort carries a zero byte and ends the frame
    a_timeout_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (r_status_reg == ST_TIMEOUT)) |->
            r_end_reg && (r_byte_reg == 8'd0))
        else $error("timeout result without frame end or with data");

    // A processed transaction either hands its result on or has none
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_axis_tready) |-> !proc_fire)
        else $error("result register overwritten while stalled");
`endif

endmodule

// ----- tb/request_frame_receiver_crc16_unit_tb.sv -----
// Self-checking testbench for request_frame_receiver_crc16_unit: streams request
// frames, millisecond ticks and noise, and checks every tagged byte report.
// Depends on rfr_pkg and the RTL of the frame receiver.
`timescale 1ns / 100ps

typedef struct packed {
    logic [7:0]  byte_val;
    logic [2:0]  tag;
    logic [15:0] offset;
    logic [15:0] plen;
    logic        last;
    logic [1:0]  status;
} field_report_t;

// Tracks the frame parser state and holds the byte reports still owed by the block.
class rx_frame_tracker;
    logic [15:0]   idle_limit;
    logic [15:0]   max_len;
    logic [2:0]    phase;
    int unsigned   pos;
    logic [31:0]   len_acc;
    logic [15:0]   crc;
    logic [7:0]    crc_hi;
    logic [15:0]   idle_ticks;
    bit            in_frame;
    field_report_t due_reports[$];
    int            mismatches;

    function new();
        idle_limit = rfr_pkg::IDLE_TIMEOUT_RST;
        max_len    = rfr_pkg::MAX_PAYLOAD_RST;
        mismatches = 0;
        restart();
    endfunction

    function void restart();
        phase      = rfr_pkg::PH_TYPE;
        pos        = 0;
        len_acc    = '0;
        crc        = rfr_pkg::CRC_INIT;
        crc_hi     = '0;
        idle_ticks = '0;
        in_frame   = 1'b0;
    endfunction

    function void set_reg(logic idx, logic [15:0] val);
        if (idx == rfr_pkg::CFG_IDLE_TIMEOUT) begin
            idle_limit = val;
        end else begin
            max_len = val;
        end
    endfunction

    // Bit-serial CRC-16/CCITT-FALSE, MSB of the byte first
    static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
        logic fb;
        int   i;
        for (i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? rfr_pkg::CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function int unsigned hdr_size(logic [2:0] ph);
        case (ph)
            rfr_pkg::PH_TYPE: return rfr_pkg::TYPE_BYTES;
            rfr_pkg::PH_ID:   return rfr_pkg::ID_BYTES_DEF;
            rfr_pkg::PH_KEY:  return rfr_pkg::KEY_BYTES_DEF;
            rfr_pkg::PH_IV:   return rfr_pkg::IV_BYTES_DEF;
            default:          return rfr_pkg::LEN_BYTES;
        endcase
    endfunction

    function logic [15:0] sat_len();
        return (len_acc > 32'h0000_FFFF) ? 16'hFFFF : len_acc[15:0];
    endfunction

    // Advance the parser by one accepted input and queue the report it causes
    function void note_item(logic cmd, logic [7:0] b);
        field_report_t r;
        bit            emit;
        r.byte_val = b;
        r.tag      = phase;
        r.offset   = pos[15:0];
        r.plen     = sat_len();
        r.last     = 1'b0;
        r.status   = rfr_pkg::ST_OK;
        emit       = 1'b1;
        if (cmd == rfr_pkg::CMD_TICK) begin
            emit = 1'b0;
            if (in_frame) begin
                if (idle_ticks != 16'hFFFF) idle_ticks++;
                if (idle_ticks >= idle_limit) begin
                    r.byte_val = 8'h00;
                    r.last     = 1'b1;
                    r.status   = rfr_pkg::ST_TIMEOUT;
                    emit       = 1'b1;
                    restart();
                end
            end
        end else begin
            idle_ticks = '0;
            in_frame   = 1'b1;
            if (phase <= rfr_pkg::PH_LEN) begin
                crc = crc_step(crc, b);
                if (phase == rfr_pkg::PH_LEN) len_acc = {len_acc[23:0], b};
                if (pos + 32'd1 >= hdr_size(phase)) begin
                    pos = 0;
                    if (phase == rfr_pkg::PH_LEN) begin
                        if (len_acc > {16'h0000, max_len}) begin
                            r.last   = 1'b1;
                            r.status = rfr_pkg::ST_TOO_LONG;
                        end else begin
                            phase = (len_acc == 0) ? rfr_pkg::PH_CRC : rfr_pkg::PH_PAYLOAD;
                        end
                    end else begin
                        phase = phase + 3'd1;
                    end
                end else begin
                    pos++;
                end
            end else if (phase == rfr_pkg::PH_PAYLOAD) begin
                crc = crc_step(crc, b);
                if (pos + 32'd1 >= len_acc) begin
                    pos   = 0;
                    phase = rfr_pkg::PH_CRC;
                end else begin
                    pos = (pos + 32'd1) & 32'h0000_FFFF;
                end
            end else if (pos == 0) begin
                crc_hi = b;
                pos    = 1;
            end else begin
                r.last   = 1'b1;
                r.status = ({crc_hi, b} == crc) ? rfr_pkg::ST_OK : rfr_pkg::ST_CRC_BAD;
            end
            r.plen = sat_len();
            if (r.last) restart();
        end
        if (emit) due_reports.push_back(r);
    endfunction

    // Compare one report from the block with the oldest one owed
    function void check_report(logic [rfr_pkg::TDATA_W-1:0] d, logic [2:0] u, logic l);
        field_report_t e;
        if (due_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected report: tdata %h tuser %0d tlast %0b", d, u, l);
            return;
        end
        e = due_reports.pop_front();
        if (d[7:0] !== e.byte_val || d[23:8] !== e.offset || d[39:24] !== e.plen ||
            d[41:40] !== e.status || d[47:42] !== 6'd0 || u !== e.tag || l !== e.last) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: expected byte %02h tag %0d off %0d len %0d last %0b st %0d",
                         e.byte_val, e.tag, e.offset, e.plen, e.last, e.status);
                $display("          got      byte %02h tag %0d off %0d len %0d last %0b st %0d pad %h",
                         d[7:0], u, d[23:8], d[39:24], l, d[41:40], d[47:42]);
            end
        end
    endfunction
endclass

module request_frame_receiver_crc16_unit_tb;
    import rfr_pkg::*;

    // Bytes from the type field through the length field
    localparam int HEADER_BYTES = TYPE_BYTES + ID_BYTES_DEF + KEY_BYTES_DEF + IV_BYTES_DEF
                                  + LEN_BYTES;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata  = 8'h00;   // [7:0] rx_byte
    logic                s_axis_tuser  = 1'b0;    // [0] cmd
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // [7:0] out_byte, [23:8] field_offset, [39:24] payload_len, [41:40] status
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic [2:0]          m_axis_tuser;            // [2:0] field_tag
    logic                m_axis_tlast;            // frame_end
    logic                cfg_we        = 1'b0;
    logic                cfg_addr      = 1'b0;
    logic [15:0]         cfg_wdata     = 16'h0000;

    // Set for one whole setting so that both channels run back to back for a while
    bit                  no_gaps       = 1'b0;
    int                  items_sent    = 0;
    rx_frame_tracker     frames        = new();

    request_frame_receiver_crc16_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 0;
    end

    // Result side: check every transaction seen at the edge, then pick the next
    // tready. Values read here are the ones before this edge's updates.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            frames.check_report(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 38);
    end

    // Offer one input and hold it until the block takes it. Random idle cycles
    // go in front; tvalid is only lowered in steps where it is not raised.
    task automatic push_item(input logic cmd, input logic [7:0] b);
        while (!no_gaps && $urandom_range(0, 99) < 38) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= b;
        do @(posedge aclk); while (!s_axis_tready);
        frames.note_item(cmd, b);
        items_sent++;
    endtask

    // A tick carries a random byte, which the block must ignore
    task automatic push_tick();
        push_item(CMD_TICK, 8'($urandom));
    endtask

    // Sometimes idle inside a frame, always short of the timeout
    task automatic idle_gap_ticks();
        if (frames.idle_limit >= 2 && $urandom_range(0, 19) == 0)
            repeat ($urandom_range(1, (frames.idle_limit > 6) ? 6 : frames.idle_limit - 1))
                push_tick();
    endtask

    // Stop offering input, wait until every owed report has come, then let the
    // two-stage pipeline settle after any trailing tick that owes nothing.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (frames.due_reports.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        frames.set_reg(idx, val);
        @(posedge aclk);
    endtask

    // One sequence: mostly a whole frame with random content, sometimes a bad
    // CRC, an oversized length, a frame cut off by the idle timeout, or noise.
    task automatic send_frame();
        int unsigned pick, cap, cut, idx;
        bit          short_fuse, too_long, bad_crc, truncate;
        logic [31:0] len_word;
        logic [15:0] crc_word;
        logic [7:0]  body[$];
        short_fuse = (frames.idle_limit <= 8);
        // Realign on the type field: time out a partial frame, or pad it with zeros
        while (frames.in_frame) begin
            if (short_fuse) push_tick();
            else push_item(CMD_BYTE, 8'h00);
        end
        pick = $urandom_range(0, 99);
        if (pick < 8 && short_fuse) begin
            repeat ($urandom_range(1, 6)) push_item(1'($urandom_range(0, 1)), 8'($urandom));
            return;
        end
        // Ticks with nothing in progress owe nothing
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 2)) push_tick();
        too_long = (pick >= 8 && pick < 20);
        bad_crc  = (pick >= 20 && pick < 32);
        truncate = short_fuse && pick >= 32 && pick < 44;

        cap = (frames.max_len < 48) ? frames.max_len : 48;
        if (too_long) begin
            if ($urandom_range(0, 1)) len_word = $urandom | 32'h0001_0000;
            else len_word = 32'(frames.max_len) + $urandom_range(1, 4);
        end else if ($urandom_range(0, 7) == 0) begin
            len_word = $urandom_range(0, cap);
        end else begin
            len_word = $urandom_range(0, (cap < 6) ? cap : 6);
        end

        repeat (HEADER_BYTES - LEN_BYTES) body.push_back(8'($urandom));
        body.push_back(len_word[31:24]);
        body.push_back(len_word[23:16]);
        body.push_back(len_word[15:8]);
        body.push_back(len_word[7:0]);
        if (!too_long) repeat (len_word) body.push_back(8'($urandom));

        cut = truncate ? $urandom_range(1, body.size()) : body.size();
        for (idx = 0; idx < cut; idx++) begin
            push_item(CMD_BYTE, body[idx]);
            idle_gap_ticks();
        end

        if (truncate) begin
            // Exactly as many ticks as the timeout needs
            while (frames.in_frame) push_tick();
        end else if (!too_long) begin
            // The tracker's running CRC is the one the frame must carry
            crc_word = frames.crc;
            if (bad_crc) crc_word = crc_word ^ 16'($urandom_range(1, 65535));
            push_item(CMD_BYTE, crc_word[15:8]);
            idle_gap_ticks();
            push_item(CMD_BYTE, crc_word[7:0]);
        end
    endtask

    initial begin
        logic [15:0] timeouts [0:6];
        logic [15:0] max_lens [0:6];
        int          p, start;
        timeouts = '{16'd10000, 16'd1, 16'd3, 16'd65535, 16'd5, 16'd2, 16'd4};
        max_lens = '{16'd1024, 16'd0, 16'd16, 16'd65535, 16'd40, 16'd1, 16'd300};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: ticks with no frame, extreme bytes, idling under the default
        // timeout, then a zero timeout that aborts on the very first tick.
        push_tick();
        push_tick();
        push_item(CMD_BYTE, 8'h00);
        push_item(CMD_BYTE, 8'hFF);
        push_item(CMD_BYTE, 8'hA5);
        push_tick();
        push_tick();
        drain();
        write_reg(CFG_IDLE_TIMEOUT, 16'd0);
        push_tick();
        push_tick();
        drain();

        // Random phases, one register setting each
        for (p = 0; p < 7; p++) begin
            write_reg(CFG_IDLE_TIMEOUT, timeouts[p]);
            write_reg(CFG_MAX_PAYLOAD, max_lens[p]);
            no_gaps <= (p == 3);
            start = items_sent;
            while (items_sent - start < 250) send_frame();
            drain();
        end

        if (frames.mismatches == 0 && frames.due_reports.size() == 0)
            $display("request_frame_receiver_crc16_unit_tb: PASS");
        else
            $display("request_frame_receiver_crc16_unit_tb: FAIL");
        $finish;
    end

    // Hard stop far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("request_frame_receiver_crc16_unit_tb: FAIL");
        $finish;
    end

endmodule
